// ===== src/iso8601_instant_parser_unit_assert.svh =====
// Assertion macros shared by the checker of the instant parser.
// No dependencies; included by iso_checker.sv.
`ifndef ISO8601_INSTANT_PARSER_UNIT_ASSERT_SVH
`define ISO8601_INSTANT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define ISO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/iso_pkg.sv =====
// Types, constants and small tables of the instant parser.
// No dependencies; used by all modules of the block.
package iso_pkg;

    localparam int FRACTION_DIGITS_DEF = 9;

    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

    // 719468 plus one 400-year era (146097): year is biased by 400
    localparam logic [23:0] DAYS_BIAS   = 24'd865565;
    localparam logic [23:0] DAYS_PER_YR = 24'd365;
    localparam logic [6:0]  YEAR_SHIFT  = 7'd0;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] frac;
        logic [3:0]  frac_count;
        logic        off_neg;
        logic [6:0]  off_hours;
        logic [6:0]  off_minutes;
        logic        off_flag;
    } rec_t;

    // day of year counted from March 1st
    function automatic logic [8:0] march_doy_base(input logic [6:0] m);
        logic [8:0] r;
        case (m)
            7'd3:    r = 9'd0;
            7'd4:    r = 9'd31;
            7'd5:    r = 9'd61;
            7'd6:    r = 9'd92;
            7'd7:    r = 9'd122;
            7'd8:    r = 9'd153;
            7'd9:    r = 9'd184;
            7'd10:   r = 9'd214;
            7'd11:   r = 9'd245;
            7'd12:   r = 9'd275;
            7'd1:    r = 9'd306;
            7'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            7'd2:                          r = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:       r = 5'd30;
            default:                       r = 5'd31;
        endcase
        return r;
    endfunction

    // scale of a fraction with k kept digits to nanoseconds
    function automatic logic [29:0] frac_scale(input logic [3:0] k);
        logic [29:0] r;
        case (k)
            4'd1:    r = 30'd100000000;
            4'd2:    r = 30'd10000000;
            4'd3:    r = 30'd1000000;
            4'd4:    r = 30'd100000;
            4'd5:    r = 30'd10000;
            4'd6:    r = 30'd1000;
            4'd7:    r = 30'd100;
            4'd8:    r = 30'd10;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

    // floor(x / 25) for x below 2600, by reciprocal multiply
    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [24:0] p;
        p = {13'd0, x} * 25'd5243;
        return p[24:17];
    endfunction

endpackage

// ===== src/iso_front.sv =====
// Character parser: validates the text shape and collects the fields.
// Depends on iso_pkg; pushes one record per string into the queue.
module iso_front #(
    parameter int FRACTION_DIGITS = iso_pkg::FRACTION_DIGITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic [7:0]     char_byte,
    input  logic           last_char,
    output logic           rec_push,
    output iso_pkg::rec_t  rec
);

    typedef enum logic [4:0] {
        PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_SEP, PH_HOUR, PH_COLON1,
        PH_MIN, PH_COLON2, PH_SEC, PH_ZONE, PH_FRAC, PH_OFFH, PH_OFFSEP,
        PH_OFFCOLON, PH_OFFM, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next, day_reg, day_next, hour_reg, hour_next;
    logic [6:0]  min_reg, min_next, sec_reg, sec_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic        neg_reg, neg_next, oflag_reg, oflag_next, err_reg, err_next;
    logic [6:0]  offh_reg, offh_next, offm_reg, offm_next;

    logic       is_dig, is_zulu, is_sign, end_ok;
    logic [3:0] dval;

    assign is_dig  = (char_byte >= 8'd48) && (char_byte <= 8'd57);
    assign dval    = 4'(char_byte - 8'd48);
    assign is_zulu = (char_byte == "Z") || (char_byte == "z");
    assign is_sign = (char_byte == "+") || (char_byte == "-");

    always_comb begin
        phase_next = phase_reg;  idx_next   = idx_reg;   year_next = year_reg;
        month_next = month_reg;  day_next   = day_reg;   hour_next = hour_reg;
        min_next   = min_reg;    sec_next   = sec_reg;   frac_next = frac_reg;
        fcnt_next  = fcnt_reg;   neg_next   = neg_reg;   oflag_next = oflag_reg;
        err_next   = err_reg;    offh_next  = offh_reg;  offm_next = offm_reg;
        if (!err_reg) begin
            case (phase_reg)
                PH_YEAR: begin
                    if (!is_dig) begin
                        err_next = 1'b1;
                    end else begin
                        year_next = 14'(year_reg * 14'd10 + {10'd0, dval});
                        if (idx_reg == 3'd3) begin
                            idx_next = 3'd0; phase_next = PH_DASH1;
                        end else begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
                PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_OFFH: begin
                    if (!is_dig) begin
                        err_next = 1'b1;
                    end else begin
                        case (phase_reg)
                            PH_MONTH: month_next = 7'(month_reg * 7'd10 + {3'd0, dval});
                            PH_DAY:   day_next   = 7'(day_reg * 7'd10 + {3'd0, dval});
                            PH_HOUR:  hour_next  = 7'(hour_reg * 7'd10 + {3'd0, dval});
                            PH_MIN:   min_next   = 7'(min_reg * 7'd10 + {3'd0, dval});
                            PH_SEC:   sec_next   = 7'(sec_reg * 7'd10 + {3'd0, dval});
                            default:  offh_next  = 7'(offh_reg * 7'd10 + {3'd0, dval});
                        endcase
                        if (idx_reg == 3'd1) begin
                            idx_next = 3'd0;
                            case (phase_reg)
                                PH_MONTH: phase_next = PH_DASH2;
                                PH_DAY:   phase_next = PH_SEP;
                                PH_HOUR:  phase_next = PH_COLON1;
                                PH_MIN:   phase_next = PH_COLON2;
                                PH_SEC:   phase_next = PH_ZONE;
                                default:  phase_next = PH_OFFSEP;
                            endcase
                        end else begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
                PH_DASH1: if (char_byte == "-") phase_next = PH_MONTH; else err_next = 1'b1;
                PH_DASH2: if (char_byte == "-") phase_next = PH_DAY; else err_next = 1'b1;
                PH_COLON1: if (char_byte == ":") phase_next = PH_MIN; else err_next = 1'b1;
                PH_COLON2: if (char_byte == ":") phase_next = PH_SEC; else err_next = 1'b1;
                PH_SEP: begin
                    if (char_byte == "T" || char_byte == "t" || char_byte == " ")
                        phase_next = PH_HOUR;
                    else
                        err_next = 1'b1;
                end
                PH_ZONE, PH_FRAC: begin
                    if (phase_reg == PH_FRAC && is_dig) begin
                        if (32'(fcnt_reg) < FRACTION_DIGITS) begin
                            frac_next = 30'(frac_reg * 30'd10 + {26'd0, dval});
                            fcnt_next = fcnt_reg + 4'd1;
                        end
                    end else if (phase_reg == PH_FRAC && fcnt_reg == 4'd0) begin
                        err_next = 1'b1;
                    end else if (phase_reg == PH_ZONE && char_byte == ".") begin
                        phase_next = PH_FRAC; fcnt_next = 4'd0; frac_next = 30'd0;
                    end else if (is_zulu) begin
                        oflag_next = 1'b1; phase_next = PH_DONE;
                    end else if (is_sign) begin
                        oflag_next = 1'b1;
                        neg_next   = (char_byte == "-");
                        idx_next   = 3'd0;
                        phase_next = PH_OFFH;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_OFFSEP, PH_OFFCOLON: begin
                    if (phase_reg == PH_OFFSEP && char_byte == ":") begin
                        phase_next = PH_OFFCOLON;
                    end else if (is_dig) begin
                        offm_next = {3'd0, dval}; phase_next = PH_OFFM;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_OFFM: begin
                    if (is_dig) begin
                        offm_next  = 7'(offm_reg * 7'd10 + {3'd0, dval});
                        phase_next = PH_DONE;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                default: err_next = 1'b1;
            endcase
        end
    end

    assign end_ok = (phase_next == PH_ZONE) || (phase_next == PH_OFFSEP) ||
                    (phase_next == PH_OFFCOLON) || (phase_next == PH_DONE) ||
                    (phase_next == PH_FRAC && fcnt_next != 4'd0);

    always_comb begin
        rec.ok = !err_next && end_ok && month_next >= 7'd1 && month_next <= 7'd12 &&
                 day_next >= 7'd1 && day_next <= 7'd31 && hour_next <= 7'd23 &&
                 min_next <= 7'd59 && sec_next <= 7'd60 && offh_next <= 7'd23 &&
                 offm_next <= 7'd59;
        rec.year        = year_next;
        rec.month       = month_next;
        rec.day         = day_next;
        rec.hour        = hour_next;
        rec.minute      = min_next;
        rec.second      = sec_next;
        rec.frac        = frac_next;
        rec.frac_count  = fcnt_next;
        rec.off_neg     = neg_next;
        rec.off_hours   = offh_next;
        rec.off_minutes = offm_next;
        rec.off_flag    = oflag_next;
    end

    assign rec_push = in_fire && last_char;

    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            phase_reg <= PH_YEAR;  idx_reg <= 3'd0;   year_reg <= 14'd0;
            month_reg <= 7'd0;     day_reg <= 7'd0;   hour_reg <= 7'd0;
            min_reg   <= 7'd0;     sec_reg <= 7'd0;   frac_reg <= 30'd0;
            fcnt_reg  <= 4'd0;     neg_reg <= 1'b0;   oflag_reg <= 1'b0;
            err_reg   <= 1'b0;     offh_reg <= 7'd0;  offm_reg <= 7'd0;
        end else if (in_fire) begin
            phase_reg <= phase_next; idx_reg <= idx_next;   year_reg <= year_next;
            month_reg <= month_next; day_reg <= day_next;   hour_reg <= hour_next;
            min_reg   <= min_next;   sec_reg <= sec_next;   frac_reg <= frac_next;
            fcnt_reg  <= fcnt_next;  neg_reg <= neg_next;   oflag_reg <= oflag_next;
            err_reg   <= err_next;   offh_reg <= offh_next; offm_reg <= offm_next;
        end
    end

endmodule

// ===== src/iso_queue.sv =====
// Two-entry queue of parsed records between the parser and the converter.
// Depends on iso_pkg for the record type.
module iso_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  iso_pkg::rec_t  rec_in,
    input  logic           pop,
    output iso_pkg::rec_t  rec_out,
    output logic           not_empty,
    output logic           has_space
);

    iso_pkg::rec_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_empty = count_reg != 2'd0;
    assign has_space = count_reg != 2'd2;
    assign rec_out   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= rec_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/iso_back.sv =====
// Converter: calendar check and epoch nanoseconds, one record at a time through its states.
// Depends on iso_pkg; takes records from the queue, drives the result channel.
module iso_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  iso_pkg::rec_t      rec_in,
    input  logic               rec_avail,
    output logic               rec_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_parse_ok,
    output logic               m_offset_seen,
    output logic               m_assumed_utc,
    output logic signed [63:0] m_epoch_nanos,
    output logic               m_overflow
);

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_DAYS, B_SEC, B_MUL, B_OUT} bstate_t;

    bstate_t            state_reg;
    iso_pkg::rec_t      rec_reg;
    logic [13:0]        ybig_reg;
    logic [7:0]         qy100_reg, qy400_reg, ql100_reg, ql400_reg;
    logic [8:0]         doy_reg;
    logic [29:0]        fns_reg;
    logic signed [23:0] days_reg;
    logic               ok_reg;
    logic signed [41:0] s_reg;
    logic signed [51:0] phi_reg;
    logic [49:0]        plo_reg;
    logic               valid_reg, pok_reg, oseen_reg, utc_reg, ovf_reg;
    logic signed [63:0] nanos_reg;

    logic [13:0]        ybig;
    logic               leap, out_free;
    logic [23:0]        days_pos;
    logic [16:0]        tod, offs;
    logic [6:0]         sec_c;
    logic signed [41:0] off_s;
    logic signed [73:0] full;
    logic               fits;

    assign ybig = rec_reg.year + 14'd400 - ((rec_reg.month <= 7'd2) ? 14'd1 : 14'd0);

    assign leap = (rec_reg.year[1:0] == 2'd0 &&
                   12'(ql100_reg * 12'd25) != rec_reg.year[13:2]) ||
                  (rec_reg.year[3:0] == 4'd0 &&
                   10'(ql400_reg * 10'd25) == rec_reg.year[13:4]);

    assign days_pos = 24'(ybig_reg) * iso_pkg::DAYS_PER_YR + 24'(ybig_reg[13:2]) +
                      24'(qy400_reg) + 24'(doy_reg) + 24'(iso_pkg::YEAR_SHIFT);

    assign sec_c = (rec_reg.second > 7'd59) ? 7'd59 : rec_reg.second;
    assign tod   = 17'(rec_reg.hour * 17'd3600) + 17'(rec_reg.minute * 17'd60) +
                   17'(sec_c);
    assign offs  = 17'(rec_reg.off_hours * 17'd3600) + 17'(rec_reg.off_minutes * 17'd60);
    assign off_s = rec_reg.off_neg ? -$signed({25'd0, offs}) : $signed({25'd0, offs});

    assign full = (74'(phi_reg) <<< 20) + $signed({24'd0, plo_reg}) +
                  $signed({44'd0, fns_reg});
    assign fits = full[73:63] == {11{full[63]}};

    assign out_free = !valid_reg || m_ready;
    assign rec_pop  = (state_reg == B_IDLE) && rec_avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            if (state_reg == B_OUT && out_free) valid_reg <= 1'b1;
            else if (valid_reg && m_ready) valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE: begin
                    if (rec_avail) begin
                        rec_reg   <= rec_in;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    ybig_reg  <= ybig;
                    qy100_reg <= iso_pkg::div25(ybig[13:2]);
                    qy400_reg <= iso_pkg::div25({2'd0, ybig[13:4]});
                    ql100_reg <= iso_pkg::div25(rec_reg.year[13:2]);
                    ql400_reg <= iso_pkg::div25({2'd0, rec_reg.year[13:4]});
                    doy_reg   <= iso_pkg::march_doy_base(rec_reg.month) +
                                 9'(rec_reg.day) - 9'd1;
                    fns_reg   <= 30'(rec_reg.frac * iso_pkg::frac_scale(rec_reg.frac_count));
                    state_reg <= B_DAYS;
                end
                B_DAYS: begin
                    ok_reg    <= rec_reg.ok &&
                                 rec_reg.day <= {2'd0, iso_pkg::month_days(rec_reg.month, leap)};
                    days_reg  <= $signed(days_pos - 24'(qy100_reg) - iso_pkg::DAYS_BIAS);
                    state_reg <= B_SEC;
                end
                B_SEC: begin
                    s_reg     <= 42'(days_reg) * 42'sd86400 + $signed({25'd0, tod}) - off_s;
                    state_reg <= B_MUL;
                end
                B_MUL: begin
                    phi_reg   <= 52'($signed(s_reg[41:20])) * 52'sd1000000000;
                    plo_reg   <= 50'(s_reg[19:0]) * 50'd1000000000;
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        pok_reg   <= ok_reg;
                        oseen_reg <= ok_reg && rec_reg.off_flag;
                        utc_reg   <= ok_reg && !rec_reg.off_flag;
                        ovf_reg   <= ok_reg && !fits;
                        if (!ok_reg)
                            nanos_reg <= 64'sd0;
                        else if (fits)
                            nanos_reg <= full[63:0];
                        else
                            nanos_reg <= full[73] ? iso_pkg::INT64_MIN : iso_pkg::INT64_MAX;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_valid       = valid_reg;
    assign m_parse_ok    = pok_reg;
    assign m_offset_seen = oseen_reg;
    assign m_assumed_utc = utc_reg;
    assign m_epoch_nanos = nanos_reg;
    assign m_overflow    = ovf_reg;

endmodule

// ===== src/iso8601_instant_parser_unit.sv =====
// Timestamp text to epoch nanoseconds: top level joining parser, queue and converter.
// Depends on iso_pkg, iso_front, iso_queue and iso_back.
//
// Usage: feed the timestamp one character per item on s_char_byte, with
// s_last_char high on the final character. Each string gives exactly one
// result item on the m_ channel: parse_ok, offset_seen, assumed_utc, the signed
// nanoseconds since 1970-01-01 UTC (saturated, with overflow set) and all zero
// fields other than parse_ok=0 when the text is not a valid instant.
// Throughput: one character per cycle while the two-entry record queue has
// room. The converter takes one string at a time through its steps (load,
// divide-by-25 and fraction scale, day count, seconds, two partial products,
// output).
// The record of the last character passes through the queue, then the converter
// states load, divide, days, seconds, multiply and output, into the result register.
// Reset (aresetn low, synchronous) drops any partly received string, the
// queue and a pending result. When the receiver stalls, the result register
// holds, the converter waits, and s_ready falls once the queue is full.
module iso8601_instant_parser_unit #(
    parameter int FRACTION_DIGITS = iso_pkg::FRACTION_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_byte,
    input  logic               s_last_char,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_parse_ok,
    output logic               m_offset_seen,
    output logic               m_assumed_utc,
    output logic signed [63:0] m_epoch_nanos,
    output logic               m_overflow
);

    iso_pkg::rec_t front_rec, queue_rec;
    logic          push, pop, q_avail, q_space;

    assign s_ready = q_space;

    iso_front #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .char_byte (s_char_byte),
        .last_char (s_last_char),
        .rec_push  (push),
        .rec       (front_rec)
    );

    iso_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .rec_in    (front_rec),
        .pop       (pop),
        .rec_out   (queue_rec),
        .not_empty (q_avail),
        .has_space (q_space)
    );

    iso_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec_in        (queue_rec),
        .rec_avail     (q_avail),
        .rec_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_parse_ok    (m_parse_ok),
        .m_offset_seen (m_offset_seen),
        .m_assumed_utc (m_assumed_utc),
        .m_epoch_nanos (m_epoch_nanos),
        .m_overflow    (m_overflow)
    );

endmodule

// ===== src/iso_checker.sv =====
// Port-level checks of the instant parser, bound to the top level.
// Depends on iso8601_instant_parser_unit_assert.svh and iso_pkg.
`include "iso8601_instant_parser_unit_assert.svh"

module iso_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_parse_ok,
    input logic               m_offset_seen,
    input logic               m_assumed_utc,
    input logic signed [63:0] m_epoch_nanos,
    input logic               m_overflow
);

    `ISO_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_epoch_nanos), "result dropped or changed while stalled")
    `ISO_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid && !m_parse_ok, m_epoch_nanos == 64'sd0 && !m_offset_seen && !m_assumed_utc && !m_overflow, "failed item carries data")
    `ISO_ASSERT_NOW(a_zone_excl, aclk, aresetn, m_valid && m_parse_ok, m_offset_seen != m_assumed_utc, "zone flags disagree")
    `ISO_ASSERT_NOW(a_sat, aclk, aresetn, m_valid && m_overflow, m_epoch_nanos == iso_pkg::INT64_MAX || m_epoch_nanos == iso_pkg::INT64_MIN, "overflow without saturation")

endmodule

bind iso8601_instant_parser_unit iso_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_parse_ok    (m_parse_ok),
    .m_offset_seen (m_offset_seen),
    .m_assumed_utc (m_assumed_utc),
    .m_epoch_nanos (m_epoch_nanos),
    .m_overflow    (m_overflow)
);
